@@ rtl/core/sbgs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbgs_pkg: shared types and constants of the SOR gain solver
// Action codes, register indexes, fixed-point limits and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbgs_pkg;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_SOLVE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH      = 3'd0;
    localparam logic [2:0] REG_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_LAMBDA1    = 3'd2;
    localparam logic [2:0] REG_LAMBDA2    = 3'd3;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd4;

    // stencil sequencing
    localparam logic [3:0] TAP_LAST   = 4'd13;
    localparam logic [2:0] MUL_LAST   = 3'd4;
    localparam logic [6:0] DIV_LAST   = 7'd75;

    // fixed-point limits
    localparam logic [63:0] ACC_LIM    = 64'h0800_0000_0000_0000;
    localparam logic [63:0] HP_LIM     = 64'h0000_0800_0000_0000;
    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0000_8000;
    localparam logic [47:0] NORM_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] CONV_SCALE = 17'd100000;
    localparam logic [47:0] NORM_FLOOR = 48'd6;

    // controller states, one-hot
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_READ  = 10'b00_0000_0010,
        S_TAP   = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_SUM   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_UPD1  = 10'b00_0100_0000,
        S_UPD2  = 10'b00_1000_0000,
        S_NEXT  = 10'b01_0000_0000,
        S_CHECK = 10'b10_0000_0000
    } t_state;

    // commands from the controller
    typedef struct packed {
        logic load_we;
        logic out_plain;
        logic rd_issue;
        logic rd_done;
        logic sw_start;
        logic tap_step;
        logic mul_step;
        logic div_load;
        logic div_step;
        logic upd1;
        logic upd2;
        logic pix_next;
        logic sweep_chk;
    } t_dp_cmd;

    // status back from the datapath
    typedef struct packed {
        logic out_free;
        logic tap_last;
        logic mul_last;
        logic d_zero;
        logic div_last;
        logic pix_last;
        logic solve_end;
    } t_dp_status;

endpackage

@@ rtl/core/sor_biharmonic_gain_solver.sv @@
// ----------------------------------------------------------------------------
// sor_biharmonic_gain_solver: SOR gain solver on a 13-point stencil
// Load and read items stream through one result each; a solve runs
// in-place over-relaxation sweeps over the image interior.
// Load and unknown items set the result register; a read goes through the
//   registered store read. A solve takes each pixel through taps, multiplies,
//   bit-serial division and update, skips zero-diagonal pixels, and checks convergence per sweep.
// Throughput: one item at a time; loads can follow every cycle while results drain.
// Reset: synchronous active-low; clears control, results and registers to
//   their defaults. Pixel stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sor_biharmonic_gain_solver #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pixel_address, weight_value, force_value, gain_value
    input  logic [111:0] s_axis_tdata,
    // action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // gain_out, sweeps_done, converged, zero pad
    output logic [55:0]  m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    sbgs_pkg::t_dp_cmd    cmd;
    sbgs_pkg::t_dp_status st;
    logic [31:0]          gain_out;
    logic [15:0]          sweeps_done;
    logic                 converged;

    // sequencer
    sbgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .i_st       (st),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // datapath and stores
    sbgs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_address (s_axis_tdata[15:0]),
        .i_weight_value  (s_axis_tdata[47:16]),
        .i_force_value   (s_axis_tdata[79:48]),
        .i_gain_value    (s_axis_tdata[111:80]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_gain_out      (gain_out),
        .o_sweeps_done   (sweeps_done),
        .o_converged     (converged)
    );

    // pack result fields
    assign m_axis_tdata = {7'b0, converged, sweeps_done, gain_out};

    // input side only opens when the result register can take a result
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input accepted while result register is blocked");

    // a load transfer shows its result on the next cycle
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == sbgs_pkg::ACT_LOAD))
        |=> m_axis_tvalid)
        else $error("load transfer gave no result");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input open during result stall");

endmodule

@@ rtl/core/sbgs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbgs_ctrl: sequencer of the SOR gain solver
// Decodes accepted items and steps the datapath through taps, multiplies,
// division and update of each interior pixel, sweep after sweep.
// ----------------------------------------------------------------------------
module sbgs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_action,
    input  sbgs_pkg::t_dp_status  i_st,
    output logic                  o_in_ready,
    output sbgs_pkg::t_dp_cmd     o_cmd
);

    sbgs_pkg::t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sbgs_pkg::S_IDLE: begin
                o_in_ready = i_st.out_free;
                if (i_in_valid && i_st.out_free) begin
                    unique case (sbgs_pkg::t_action'(i_action))
                        sbgs_pkg::ACT_LOAD: begin
                            o_cmd.load_we = 1'b1;
                        end
                        sbgs_pkg::ACT_SOLVE: begin
                            o_cmd.sw_start = 1'b1;
                            n_state        = sbgs_pkg::S_TAP;
                        end
                        sbgs_pkg::ACT_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = sbgs_pkg::S_READ;
                        end
                        sbgs_pkg::ACT_NONE: begin
                            o_cmd.out_plain = 1'b1;
                        end
                    endcase
                end
            end
            sbgs_pkg::S_READ: begin
                o_cmd.rd_done = 1'b1;
                n_state       = sbgs_pkg::S_IDLE;
            end
            sbgs_pkg::S_TAP: begin
                o_cmd.tap_step = 1'b1;
                if (i_st.tap_last) n_state = sbgs_pkg::S_MUL;
            end
            sbgs_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_st.mul_last) n_state = sbgs_pkg::S_SUM;
            end
            sbgs_pkg::S_SUM: begin
                // skip pixels with a zero diagonal
                if (i_st.d_zero) begin
                    n_state = sbgs_pkg::S_NEXT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = sbgs_pkg::S_DIV;
                end
            end
            sbgs_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) n_state = sbgs_pkg::S_UPD1;
            end
            sbgs_pkg::S_UPD1: begin
                o_cmd.upd1 = 1'b1;
                n_state    = sbgs_pkg::S_UPD2;
            end
            sbgs_pkg::S_UPD2: begin
                o_cmd.upd2 = 1'b1;
                n_state    = sbgs_pkg::S_NEXT;
            end
            sbgs_pkg::S_NEXT: begin
                o_cmd.pix_next = 1'b1;
                n_state = i_st.pix_last ? sbgs_pkg::S_CHECK : sbgs_pkg::S_TAP;
            end
            sbgs_pkg::S_CHECK: begin
                o_cmd.sweep_chk = 1'b1;
                n_state = i_st.solve_end ? sbgs_pkg::S_IDLE : sbgs_pkg::S_TAP;
            end
            default: begin
                n_state = sbgs_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbgs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/sbgs_dp.sv @@
// ----------------------------------------------------------------------------
// sbgs_dp: datapath of the SOR gain solver
// Pixel stores, configuration registers, stencil accumulation, shared
// multiplier, bit-serial divider, relaxation update and result register.
// ----------------------------------------------------------------------------
module sbgs_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sbgs_pkg::t_dp_cmd     i_cmd,
    output sbgs_pkg::t_dp_status  o_st,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [15:0]           i_pixel_address,
    input  logic [31:0]           i_weight_value,
    input  logic [31:0]           i_force_value,
    input  logic [31:0]           i_gain_value,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_gain_out,
    output logic [15:0]           o_sweeps_done,
    output logic                  o_converged
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int VB    = VALUE_BITS;
    localparam int MW    = VB + 2;
    localparam int SW    = VB + 6;

    // --------------------------------------------------------------- helpers
    function automatic logic [VB-1:0] f_gsat(input logic signed [63:0] v);
        logic signed [63:0] hi_v;
        logic signed [63:0] lo_v;
        hi_v = (64'sd1 <<< (VB - 1)) - 64'sd1;
        lo_v = -(64'sd1 <<< (VB - 1));
        if (v > hi_v)      return hi_v[VB-1:0];
        else if (v < lo_v) return lo_v[VB-1:0];
        else               return v[VB-1:0];
    endfunction

    function automatic logic signed [60:0] f_acc(input logic signed [62:0] v);
        logic signed [62:0] lim;
        lim = $signed(sbgs_pkg::ACC_LIM[62:0]);
        if (v > lim)       return lim[60:0];
        else if (v < -lim) return 61'(-lim);
        else               return v[60:0];
    endfunction

    // ---------------------------------------------------------- config regs
    logic [8:0]  r_img_w, r_img_h;
    logic [31:0] r_lam1, r_lam2;
    logic [15:0] r_iter_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= 9'd256;
            r_img_h    <= 9'd256;
            r_lam1     <= 32'd65536;
            r_lam2     <= 32'd0;
            r_iter_lim <= 16'd100;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sbgs_pkg::REG_WIDTH:      r_img_w    <= i_cfg_data[8:0];
                sbgs_pkg::REG_HEIGHT:     r_img_h    <= i_cfg_data[8:0];
                sbgs_pkg::REG_LAMBDA1:    r_lam1     <= i_cfg_data;
                sbgs_pkg::REG_LAMBDA2:    r_lam2     <= i_cfg_data;
                sbgs_pkg::REG_ITER_LIMIT: r_iter_lim <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // clamp geometry and limit
    logic [31:0] w32, h32;
    logic [AW-1:0] w_a;
    logic [XB-1:0] x_end;
    logic [YB-1:0] y_end;
    logic [15:0] lim;
    logic [37:0] lam;

    always_comb begin
        if (r_img_w < 9'd5)                  w32 = 32'd5;
        else if (32'(r_img_w) > MAX_WIDTH)   w32 = 32'(MAX_WIDTH);
        else                                 w32 = 32'(r_img_w);
        if (r_img_h < 9'd5)                  h32 = 32'd5;
        else if (32'(r_img_h) > MAX_HEIGHT)  h32 = 32'(MAX_HEIGHT);
        else                                 h32 = 32'(r_img_h);
        w_a   = AW'(w32);
        x_end = XB'(w32 - 32'd3);
        y_end = YB'(h32 - 32'd3);
        lim   = (r_iter_lim == 16'd0) ? 16'd1 : r_iter_lim;
        lam   = 38'({r_lam1, 2'b00}) + 38'({r_lam2, 4'b0000}) + 38'({r_lam2, 2'b00});
    end

    // ---------------------------------------------------------------- stores
    logic [31:0]   mem_weight [DEPTH];
    logic [31:0]   mem_force  [DEPTH];
    logic [VB-1:0] mem_gain   [DEPTH];

    logic [31:0]   addr32;
    logic          in_ok;
    logic [AW-1:0] in_idx;
    logic [AW-1:0] r_a;
    logic [3:0]    r_k;
    logic [AW-1:0] tap_addr;
    logic [31:0]   r_weight_rd, r_force_rd;
    logic [VB-1:0] r_gain_rd;
    logic          g_we;
    logic [AW-1:0] g_waddr, g_raddr;
    logic [VB-1:0] g_wdata, newg_sat;

    assign addr32 = 32'(i_pixel_address);
    assign in_ok  = addr32 < 32'(DEPTH);
    assign in_idx = addr32[AW-1:0];

    // stencil tap addresses in row-major order
    always_comb begin
        unique case (r_k)
            4'd0:    tap_addr = r_a - (w_a << 1);
            4'd1:    tap_addr = r_a - w_a - AW'(1);
            4'd2:    tap_addr = r_a - w_a;
            4'd3:    tap_addr = r_a - w_a + AW'(1);
            4'd4:    tap_addr = r_a - AW'(2);
            4'd5:    tap_addr = r_a - AW'(1);
            4'd6:    tap_addr = r_a;
            4'd7:    tap_addr = r_a + AW'(1);
            4'd8:    tap_addr = r_a + AW'(2);
            4'd9:    tap_addr = r_a + w_a - AW'(1);
            4'd10:   tap_addr = r_a + w_a;
            4'd11:   tap_addr = r_a + w_a + AW'(1);
            4'd12:   tap_addr = r_a + (w_a << 1);
            default: tap_addr = r_a;
        endcase
    end

    assign g_we    = (i_cmd.load_we && in_ok) || i_cmd.upd2;
    assign g_waddr = i_cmd.upd2 ? r_a : in_idx;
    assign g_wdata = i_cmd.upd2 ? newg_sat : f_gsat(64'($signed(i_gain_value)));
    assign g_raddr = i_cmd.tap_step ? tap_addr : in_idx;

    // weight and force stores, read at the current pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && in_ok) begin
            mem_weight[in_idx] <= i_weight_value;
            mem_force[in_idx]  <= i_force_value;
        end
        r_weight_rd <= mem_weight[r_a];
        r_force_rd  <= mem_force[r_a];
    end

    // gain store
    always_ff @(posedge i_clk) begin
        if (g_we) mem_gain[g_waddr] <= g_wdata;
        r_gain_rd <= mem_gain[g_raddr];
    end

    // --------------------------------------------------------- pixel walker
    logic [XB-1:0] r_x;
    logic [YB-1:0] r_y;
    logic          pix_last;
    logic [AW-1:0] a_start;

    assign pix_last = (r_x == x_end) && (r_y == y_end);
    assign a_start  = (w_a << 1) + AW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= XB'(2);
            r_y <= YB'(2);
            r_a <= '0;
        end else if (i_cmd.sw_start || (i_cmd.pix_next && pix_last)) begin
            r_x <= XB'(2);
            r_y <= YB'(2);
            r_a <= a_start;
        end else if (i_cmd.pix_next) begin
            if (r_x == x_end) begin
                r_x <= XB'(2);
                r_y <= r_y + YB'(1);
                r_a <= r_a + AW'(5);
            end else begin
                r_x <= r_x + XB'(1);
                r_a <= r_a + AW'(1);
            end
        end
    end

    // ------------------------------------------------------ tap accumulation
    logic signed [MW-1:0] r_m1, r_m2, r_m3, gx;
    logic signed [VB-1:0] r_gc;

    assign gx = MW'($signed(r_gain_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.tap_step) begin
            r_k <= (r_k == sbgs_pkg::TAP_LAST) ? 4'd0 : r_k + 4'd1;
        end
    end

    // sort each returning tap into its ring; the store read is registered, so data trails its address
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_step) begin
            unique case (r_k)
                4'd0: begin
                    r_m1 <= '0;
                    r_m2 <= '0;
                    r_m3 <= '0;
                end
                4'd1, 4'd5, 4'd9, 4'd13:    r_m3 <= r_m3 + gx;
                4'd2, 4'd4, 4'd10, 4'd12:   r_m2 <= r_m2 + gx;
                4'd3, 4'd6, 4'd8, 4'd11:    r_m1 <= r_m1 + gx;
                4'd7:                       r_gc <= $signed(r_gain_rd);
                default: ;
            endcase
        end
    end

    // --------------------------------------------------- lambda products
    logic [2:0]           r_j;
    logic signed [SW-1:0] s2;
    logic signed [63:0]   m1_64, s2_64;
    logic [63:0]          mag_m1, mag_s2, mag_sel, r_prod, mag_sum, mag_cap;
    logic [31:0]          mul_a, mul_b;
    logic [2:0]           p_idx;
    logic                 p_neg;
    logic [48:0]          r_lo_term;
    logic signed [60:0]   r_p1, r_p2, term;

    assign s2     = (SW'(r_m1) <<< 3) - (SW'(r_m2) <<< 1) - SW'(r_m3);
    assign m1_64  = 64'(r_m1);
    assign s2_64  = 64'(s2);
    assign mag_m1 = m1_64[63] ? 64'(-m1_64) : 64'(m1_64);
    assign mag_s2 = s2_64[63] ? 64'(-s2_64) : 64'(s2_64);
    assign mag_sel = (r_j < 3'd2) ? mag_m1 : mag_s2;
    assign mul_a   = r_j[0] ? mag_sel[63:32] : mag_sel[31:0];
    assign mul_b   = (r_j < 3'd2) ? r_lam1 : r_lam2;
    assign p_idx   = r_j - 3'd1;
    assign p_neg   = (p_idx < 3'd2) ? m1_64[63] : s2_64[63];
    assign mag_sum = (r_prod << 16) + 64'(r_lo_term);
    assign mag_cap = ((r_prod > sbgs_pkg::HP_LIM) || (mag_sum > sbgs_pkg::ACC_LIM))
                     ? sbgs_pkg::ACC_LIM : mag_sum;
    assign term    = p_neg ? 61'(-$signed({1'b0, mag_cap[59:0]}))
                           : 61'($signed({1'b0, mag_cap[59:0]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
        end else if (i_cmd.mul_step) begin
            r_j <= (r_j == sbgs_pkg::MUL_LAST) ? 3'd0 : r_j + 3'd1;
        end
    end

    // shared 32x32 multiplier, then round and combine the halves
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            if (r_j != sbgs_pkg::MUL_LAST) r_prod <= 64'(mul_a) * 64'(mul_b);
            if (r_j != 3'd0) begin
                if (!p_idx[0]) begin
                    r_lo_term <= 49'((r_prod + sbgs_pkg::ROUND_HALF) >> 16);
                end else if (p_idx == 3'd1) begin
                    r_p1 <= term;
                end else begin
                    r_p2 <= term;
                end
            end
        end
    end

    // ------------------------------------------------------------- divider
    logic signed [38:0] d_val;
    logic [37:0]        ud;
    logic signed [60:0] hv, e_val;
    logic [59:0]        ue;
    logic [75:0]        r_quo;
    logic [37:0]        r_rem, r_ud;
    logic [38:0]        rem2;
    logic               r_qneg;
    logic [6:0]         r_dc;
    logic               fit;

    assign d_val = 39'($signed(r_weight_rd)) + $signed({1'b0, lam});
    assign ud    = d_val[38] ? 38'(-d_val) : 38'(d_val);
    assign hv    = f_acc(63'(r_p1) + 63'(r_p2));
    assign e_val = f_acc(63'(hv) + 63'($signed(r_force_rd)));
    assign ue    = e_val[60] ? 60'(-e_val) : 60'(e_val);
    assign rem2  = {r_rem, r_quo[75]};
    assign fit   = rem2 >= {1'b0, r_ud};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc <= '0;
        end else if (i_cmd.div_step) begin
            r_dc <= (r_dc == sbgs_pkg::DIV_LAST) ? 7'd0 : r_dc + 7'd1;
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo  <= {ue, 16'b0} + 76'(ud >> 1);
            r_rem  <= '0;
            r_ud   <= ud;
            r_qneg <= e_val[60] != d_val[38];
        end else if (i_cmd.div_step) begin
            r_rem <= fit ? 38'(rem2 - {1'b0, r_ud}) : rem2[37:0];
            r_quo <= {r_quo[74:0], fit};
        end
    end

    // ------------------------------------------------------------- update
    logic [59:0]        q_mag;
    logic signed [62:0] q_s, diff;
    logic signed [60:0] t_val;
    logic [59:0]        ut;
    logic [62:0]        x7;
    logic [60:0]        r_ur;
    logic               r_tneg;
    logic [61:0]        nsum;
    logic signed [63:0] newg;
    logic [47:0]        r_norm, r_first_norm;

    always_comb begin
        q_mag = ((|r_quo[75:60]) || (r_quo[59:0] > sbgs_pkg::ACC_LIM[59:0]))
                ? sbgs_pkg::ACC_LIM[59:0] : r_quo[59:0];
        q_s   = r_qneg ? -$signed({3'b0, q_mag}) : $signed({3'b0, q_mag});
        diff  = 63'(r_gc) - q_s;
        t_val = f_acc(diff);
        ut    = t_val[60] ? 60'(-t_val) : 60'(t_val);
        x7    = ({3'b0, ut} << 3) - {3'b0, ut};
        nsum  = 62'(r_norm) + 62'(r_ur);
        newg  = r_tneg ? 64'(r_gc) + $signed({3'b0, r_ur})
                       : 64'(r_gc) - $signed({3'b0, r_ur});
        newg_sat = f_gsat(newg);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd1) begin
            r_ur   <= 61'((x7 + 63'd2) >> 2);
            r_tneg <= t_val[60];
        end
    end

    // --------------------------------------------------------- sweep check
    logic [15:0] r_sweep;
    logic [15:0] sweep_n;
    logic [48:0] scaled;
    logic        conv;
    logic        solve_end;
    logic [15:0] r_last_sweeps;
    logic        r_last_conv;

    assign sweep_n   = r_sweep + 16'd1;
    assign scaled    = 49'(r_norm[31:0]) * 49'(sbgs_pkg::CONV_SCALE);
    assign conv      = (r_sweep != 16'd0) &&
                       (((r_norm[47:32] == 16'd0) && (scaled < 49'(r_first_norm))) ||
                        (r_norm <= sbgs_pkg::NORM_FLOOR));
    assign solve_end = conv || (sweep_n == lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep       <= '0;
            r_norm        <= '0;
            r_first_norm  <= '0;
            r_last_sweeps <= '0;
            r_last_conv   <= 1'b0;
        end else if (i_cmd.sw_start) begin
            r_sweep <= '0;
            r_norm  <= '0;
        end else if (i_cmd.upd2) begin
            r_norm <= (nsum > 62'(sbgs_pkg::NORM_MAX)) ? sbgs_pkg::NORM_MAX : nsum[47:0];
        end else if (i_cmd.sweep_chk) begin
            if (r_sweep == 16'd0) r_first_norm <= r_norm;
            r_sweep <= sweep_n;
            r_norm  <= '0;
            if (solve_end) begin
                r_last_sweeps <= sweep_n;
                r_last_conv   <= conv;
            end
        end
    end

    // --------------------------------------------------------- result reg
    logic               r_rd_ok;
    logic signed [63:0] rd64;
    logic [31:0]        rd_clamp;

    assign rd64 = 64'($signed(r_gain_rd));
    always_comb begin
        if (rd64 > 64'sh7FFF_FFFF)        rd_clamp = 32'h7FFF_FFFF;
        else if (rd64 < -64'sh8000_0000)  rd_clamp = 32'h8000_0000;
        else                              rd_clamp = rd64[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) r_rd_ok <= in_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_we || i_cmd.out_plain) begin
            o_out_valid   <= 1'b1;
            o_gain_out    <= '0;
            o_sweeps_done <= r_last_sweeps;
            o_converged   <= r_last_conv;
        end else if (i_cmd.rd_done) begin
            o_out_valid   <= 1'b1;
            o_gain_out    <= r_rd_ok ? rd_clamp : 32'd0;
            o_sweeps_done <= r_last_sweeps;
            o_converged   <= r_last_conv;
        end else if (i_cmd.sweep_chk && solve_end) begin
            o_out_valid   <= 1'b1;
            o_gain_out    <= '0;
            o_sweeps_done <= sweep_n;
            o_converged   <= conv;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------- status
    assign o_st.out_free  = !o_out_valid || i_out_ready;
    assign o_st.tap_last  = r_k == sbgs_pkg::TAP_LAST;
    assign o_st.mul_last  = r_j == sbgs_pkg::MUL_LAST;
    assign o_st.d_zero    = d_val == 39'sd0;
    assign o_st.div_last  = r_dc == sbgs_pkg::DIV_LAST;
    assign o_st.pix_last  = pix_last;
    assign o_st.solve_end = solve_end;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the SOR gain solver
// Streams load, solve, read and unknown items into the block, runs its own
// fixed-point relaxation predictor on every accepted transfer, and compares
// each result transfer field by field. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH      = 65536;
    localparam int          MAX_W      = 256;
    localparam int          MAX_H      = 256;
    localparam longint      SAT_LIM    = 64'sh0800_0000_0000_0000;
    localparam longint      NORM_TOP   = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint      CYCLE_CAP  = 4000000;

    typedef struct {
        logic [31:0] gain;
        logic [15:0] sweeps;
        logic        conv;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    // predictor state
    int      weight_mem [DEPTH];
    int      force_mem  [DEPTH];
    longint  gain_mem   [DEPTH];
    longint  first_sum;
    int      sweep_count;
    bit      conv_flag;
    int      cfg_w, cfg_h, cfg_limit;
    longint  cfg_l1, cfg_l2;

    t_result pending_results [$];
    int      errors;
    bit      calm;
    longint  cycles;

    sor_biharmonic_gain_solver u_top (.*);

    always #10 i_clk = ~i_clk;

    // abort on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("%0t timeout", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------
    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_mag(longint unsigned m, bit neg);
        if (m > SAT_LIM) m = SAT_LIM;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // round(a*b/2^16), b unsigned Q16.16
    function automatic longint mul_q(longint a, longint b);
        longint unsigned ua, hi, lo, hp, m;
        ua = a < 0 ? -a : a;
        hi = ua >> 32;
        lo = ua & 64'hFFFF_FFFF;
        hp = hi * longint'(b);
        if (hp > (SAT_LIM >> 16)) return sat_mag(SAT_LIM, a < 0);
        m = (hp << 16) + ((lo * b + 64'h8000) >> 16);
        return sat_mag(m, a < 0);
    endfunction

    // round(e*2^16/d)
    function automatic longint div_q(longint e, longint d);
        longint unsigned ue, ud, qi, rm, m;
        ue = e < 0 ? -e : e;
        ud = d < 0 ? -d : d;
        qi = ue / ud;
        rm = ue % ud;
        if (qi > (SAT_LIM >> 16)) return sat_mag(SAT_LIM, (e < 0) != (d < 0));
        m = (qi << 16) + (((rm << 16) + ud / 2) / ud);
        return sat_mag(m, (e < 0) != (d < 0));
    endfunction

    function automatic longint relax_sweep(int w, int h, longint lam);
        longint sum, d, m1, m2, m3, hv, q, t, ur;
        int a;
        sum = 0;
        for (int y = 2; y + 2 < h; y++) begin
            for (int x = 2; x + 2 < w; x++) begin
                a = y * w + x;
                d = longint'(weight_mem[a]) + lam;
                if (d == 0) continue;
                m1 = gain_mem[a-w] + gain_mem[a-1] + gain_mem[a+1] + gain_mem[a+w];
                m2 = gain_mem[a-w-1] + gain_mem[a-w+1] + gain_mem[a+w-1] + gain_mem[a+w+1];
                m3 = gain_mem[a-2*w] + gain_mem[a-2] + gain_mem[a+2] + gain_mem[a+2*w];
                hv = clip(mul_q(m1, cfg_l1) + mul_q(8*m1 - 2*m2 - m3, cfg_l2),
                          -SAT_LIM, SAT_LIM);
                q  = div_q(clip(hv + longint'(force_mem[a]), -SAT_LIM, SAT_LIM), d);
                t  = clip(gain_mem[a] - q, -SAT_LIM, SAT_LIM);
                ur = ((t < 0 ? -t : t) * 7 + 2) >>> 2;
                sum += ur;
                if (sum > NORM_TOP) sum = NORM_TOP;
                gain_mem[a] = clip(t < 0 ? gain_mem[a] + ur : gain_mem[a] - ur,
                                   -64'sd2147483648, 64'sd2147483647);
            end
        end
        return sum;
    endfunction

    function automatic void relax_image();
        int w, h, lim;
        longint lam, s;
        w   = int'(clip(cfg_w, 5, MAX_W));
        h   = int'(clip(cfg_h, 5, MAX_H));
        lim = cfg_limit == 0 ? 1 : cfg_limit;
        lam = 4 * cfg_l1 + 20 * cfg_l2;
        conv_flag   = 1'b0;
        sweep_count = lim;
        for (int i = 0; i < lim; i++) begin
            s = relax_sweep(w, h, lam);
            if (i == 0) begin
                first_sum = s;
            end else if ((s <= 64'hFFFF_FFFF && s * 100000 < first_sum) || s <= 6) begin
                conv_flag   = 1'b1;
                sweep_count = i + 1;
                break;
            end
        end
    endfunction

    // apply one accepted item to the predictor and queue its result
    function automatic void predict_item(sbgs_pkg::t_action act, logic [15:0] addr,
                                         logic [31:0] wv, logic [31:0] fv, logic [31:0] gv);
        t_result r;
        r.gain = '0;
        case (act)
            sbgs_pkg::ACT_LOAD: begin
                weight_mem[addr] = $signed(wv);
                force_mem[addr]  = $signed(fv);
                gain_mem[addr]   = longint'($signed(gv));
            end
            sbgs_pkg::ACT_SOLVE: relax_image();
            sbgs_pkg::ACT_READ:  r.gain = gain_mem[addr][31:0];
            default: ;
        endcase
        r.sweeps = sweep_count[15:0];
        r.conv   = conv_flag;
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // result side: check each transfer, stall in random bursts
    // ------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_result e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: got %h", $time, m_axis_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== e.gain) begin
                    $display("%0t gain_out: expected %h, got %h", $time, e.gain,
                             m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== e.sweeps) begin
                    $display("%0t sweeps_done: expected %0d, got %0d", $time, e.sweeps,
                             m_axis_tdata[47:32]);
                    errors++;
                end
                if (m_axis_tdata[48] !== e.conv) begin
                    $display("%0t converged: expected %b, got %b", $time, e.conv,
                             m_axis_tdata[48]);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && !calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(sbgs_pkg::t_action act, logic [15:0] addr,
                             logic [31:0] wv = '0, logic [31:0] fv = '0,
                             logic [31:0] gv = '0);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {gv, fv, wv, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(act, addr, wv, fv, gv);
    endtask

    // hold the stream idle until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            sbgs_pkg::REG_WIDTH:      cfg_w     = int'(val[8:0]);
            sbgs_pkg::REG_HEIGHT:     cfg_h     = int'(val[8:0]);
            sbgs_pkg::REG_LAMBDA1:    cfg_l1    = longint'(val);
            sbgs_pkg::REG_LAMBDA2:    cfg_l2    = longint'(val);
            sbgs_pkg::REG_ITER_LIMIT: cfg_limit = int'(val[15:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup(int w, int h, logic [31:0] l1, logic [31:0] l2, int lim);
        drain();
        write_reg(sbgs_pkg::REG_WIDTH, w);
        write_reg(sbgs_pkg::REG_HEIGHT, h);
        write_reg(sbgs_pkg::REG_LAMBDA1, l1);
        write_reg(sbgs_pkg::REG_LAMBDA2, l2);
        write_reg(sbgs_pkg::REG_ITER_LIMIT, lim);
    endtask

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 2**19) - 2**18;
    endfunction

    // fill every pixel of the active image, with noise items in between
    task automatic load_image(int w, int h);
        for (int a = 0; a < w * h; a++) begin
            if ($urandom_range(0, 15) == 0) send_item(sbgs_pkg::ACT_NONE, 16'($urandom));
            send_item(sbgs_pkg::ACT_LOAD, 16'(a), rand_value(), rand_value(), rand_value());
        end
    endtask

    task automatic read_interior(int w, int h);
        for (int y = 2; y + 2 < h; y++)
            for (int x = 2; x + 2 < w; x++)
                send_item(sbgs_pkg::ACT_READ, 16'(y * w + x));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        setup(5, 5, 32'h0001_0000, 32'h0000_4000, 50);
        send_item(sbgs_pkg::ACT_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(sbgs_pkg::ACT_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int a = 2; a < 25; a++)
            send_item(sbgs_pkg::ACT_LOAD, 16'(a), 32'h0001_0000, rand_value(), rand_value());
        send_item(sbgs_pkg::ACT_SOLVE, 0);
        send_item(sbgs_pkg::ACT_READ, 12);
        send_item(sbgs_pkg::ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sbgs_pkg::ACT_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sbgs_pkg::ACT_READ, 16'hFFFF);
    endtask

    // interior diagonal cancels out: every pixel is skipped; limit 0 acts as 1
    task automatic test_zero_diagonal();
        setup(5, 5, 32'h0001_0000, 32'h0, 0);
        for (int a = 0; a < 25; a++)
            send_item(sbgs_pkg::ACT_LOAD, 16'(a), a == 12 ? -32'sd262144 : 32'h0001_0000,
                      rand_value(), rand_value());
        send_item(sbgs_pkg::ACT_SOLVE, 0);
        send_item(sbgs_pkg::ACT_READ, 12);
    endtask

    // settled image converges on the second sweep under the largest limit
    task automatic test_long_limit();
        setup(6, 5, 32'h0001_0000, 32'h0, 65535);
        for (int a = 0; a < 30; a++)
            send_item(sbgs_pkg::ACT_LOAD, 16'(a), 32'h0001_0000, 32'h0, 32'h0);
        send_item(sbgs_pkg::ACT_SOLVE, 0);
        read_interior(6, 5);
    endtask

    // largest lambda values; tiny sizes clamp up to 5
    task automatic test_extreme_weights();
        setup(2, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
        load_image(5, 5);
        send_item(sbgs_pkg::ACT_SOLVE, 0);
        read_interior(5, 5);
        setup(5, 5, 32'h0, 32'h0, 2);
        send_item(sbgs_pkg::ACT_SOLVE, 0);
        read_interior(5, 5);
    endtask

    // wide rows and oversized widths: loads and reads across the address space
    task automatic test_scattered_access();
        logic [15:0] addrs [$];
        logic [15:0] ad;
        setup(511, 256, 32'h0001_0000, 32'h0, 100);
        write_reg(sbgs_pkg::REG_WIDTH, 256);
        for (int i = 0; i < 40; i++) begin
            ad = 16'($urandom);
            addrs.push_back(ad);
            send_item(sbgs_pkg::ACT_LOAD, ad, $urandom, $urandom, $urandom);
        end
        foreach (addrs[i]) send_item(sbgs_pkg::ACT_READ, addrs[i]);
    endtask

    task automatic test_random_solves();
        int w, h;
        for (int r = 0; r < 12; r++) begin
            if (r >= 9) calm = 1'b1;
            w = $urandom_range(5, r % 4 == 3 ? 8 : 7);
            h = $urandom_range(5, r % 4 == 1 ? 8 : 7);
            setup(w, h, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2**18),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2**16),
                  $urandom_range(1, 25));
            load_image(w, h);
            for (int k = 0; k < 4; k++)
                send_item(sbgs_pkg::ACT_READ, 16'($urandom_range(0, w * h - 1)));
            send_item(sbgs_pkg::ACT_SOLVE, 0);
            read_interior(w, h);
            if ($urandom_range(0, 1)) begin
                send_item(sbgs_pkg::ACT_SOLVE, 0);
                send_item(sbgs_pkg::ACT_READ, 16'($urandom_range(0, w * h - 1)));
            end
        end
    endtask

    initial begin
        cfg_w = 256; cfg_h = 256; cfg_l1 = 65536; cfg_l2 = 0; cfg_limit = 100;
        first_sum = 0; sweep_count = 0; conv_flag = 0;
        errors = 0; calm = 0; cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_zero_diagonal();
        test_long_limit();
        test_extreme_weights();
        test_scattered_access();
        test_random_solves();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
